// ----- rtl/stt_pkg.sv -----
// stt_pkg: types, codes and the keyword lookup for the source text tokenizer
// no dependencies
`default_nettype none
package stt_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int LENGTH_BITS_DEF = 16;
	localparam int MAX_RES         = 6;
	localparam int WORD_MAX        = 6;

	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_EQ    = 8'h3d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_UNDER = 8'h5f;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BSL   = 8'h5c;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_IDENT   = 3'd1,
		MODE_NUM     = 3'd2,
		MODE_STR     = 3'd3,
		MODE_COMMENT = 3'd4,
		MODE_OPER    = 3'd5
	} mode_t;

	typedef enum logic [3:0] {
		KIND_IDENT   = 4'd0,
		KIND_NUM     = 4'd1,
		KIND_STR     = 4'd2,
		KIND_COMMENT = 4'd3,
		KIND_OP      = 4'd4,
		KIND_SEP     = 4'd5,
		KIND_PUNCT   = 4'd6,
		KIND_KEYWORD = 4'd7,
		KIND_BAD     = 4'd8,
		KIND_EOF     = 4'd9,
		KIND_UNTERM  = 4'd10
	} kind_t;

	typedef struct packed {
		logic        is_record;
		logic [3:0]  token_kind;
		logic [4:0]  keyword_code;
		logic [7:0]  payload_byte;
		logic [15:0] line_number;
		logic [15:0] token_length;
		logic        last_result;
	} result_t;

	function automatic logic [4:0] keyword_lookup(input logic [47:0] w, input logic [2:0] n);
		logic [4:0] code;
		code = 5'd0;
		if      (n == 3'd4 && w == 48'("true"))   code = 5'd1;
		else if (n == 3'd5 && w == 48'("false"))  code = 5'd2;
		else if (n == 3'd3 && w == 48'("for"))    code = 5'd3;
		else if (n == 3'd6 && w == 48'("return")) code = 5'd4;
		else if (n == 3'd5 && w == 48'("defun"))  code = 5'd5;
		else if (n == 3'd5 && w == 48'("local"))  code = 5'd6;
		else if (n == 3'd6 && w == 48'("global")) code = 5'd7;
		else if (n == 3'd2 && w == 48'("as"))     code = 5'd8;
		else if (n == 3'd5 && w == 48'("begin"))  code = 5'd9;
		else if (n == 3'd3 && w == 48'("end"))    code = 5'd10;
		else if (n == 3'd2 && w == 48'("if"))     code = 5'd11;
		else if (n == 3'd4 && w == 48'("then"))   code = 5'd12;
		else if (n == 3'd4 && w == 48'("else"))   code = 5'd13;
		else if (n == 3'd4 && w == 48'("elif"))   code = 5'd14;
		else if (n == 3'd5 && w == 48'("while"))  code = 5'd15;
		else if (n == 3'd3 && w == 48'("and"))    code = 5'd16;
		else if (n == 3'd2 && w == 48'("or"))     code = 5'd17;
		return code;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_quote(input logic [7:0] c);
		return c == 8'h22 || c == 8'h27;
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return c == CH_EQ || c == 8'h2b || c == CH_MINUS || c == 8'h2f || c == 8'h2a ||
			c == 8'h3c || c == 8'h3e || c == 8'h21 || c == 8'h25;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/stt_text_if.sv -----
// stt_text_if: byte request channel into the tokenizer
// no dependencies
`default_nettype none
interface stt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       final_byte;
	modport source (output valid, source_byte, final_byte, input ready);
	modport sink (input valid, source_byte, final_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/stt_token_if.sv -----
// stt_token_if: result request channel out of the tokenizer
// no dependencies
`default_nettype none
interface stt_token_if;
	logic        valid;
	logic        ready;
	logic        is_record;
	logic [3:0]  token_kind;
	logic [4:0]  keyword_code;
	logic [7:0]  payload_byte;
	logic [15:0] line_number;
	logic [15:0] token_length;
	logic        last_result;
	modport source (output valid, is_record, token_kind, keyword_code, payload_byte,
		line_number, token_length, last_result, input ready);
	modport sink (input valid, is_record, token_kind, keyword_code, payload_byte,
		line_number, token_length, last_result, output ready);
endinterface
`default_nettype wire

// ----- rtl/source_text_tokenizer.sv -----
// source_text_tokenizer: streaming lexer, one byte in, up to five results out
// depends on stt_pkg, stt_text_if, stt_token_if
`default_nettype none
// One byte request is taken per cycle while the result bank is empty or its last
// result is leaving; all of its results (zero to five) are computed in that cycle
// and land in a result register bank, which then drains one result per cycle while
// token.ready is high. The next byte is taken in the cycle the last of those results
// leaves. Bytes that give no result (spaces, quotes, held operators) pass at one per
// cycle. Line and length counts saturate.
module source_text_tokenizer #(
	parameter int LINE_BITS   = stt_pkg::LINE_BITS_DEF,
	parameter int LENGTH_BITS = stt_pkg::LENGTH_BITS_DEF
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	stt_text_if.sink    text,
	stt_token_if.source token
);
	import stt_pkg::*;

	localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
	localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
	localparam logic [LENGTH_BITS-1:0] LEN_ONE  = LENGTH_BITS'(1);

	mode_t                  mode_q;
	logic [7:0]             held_q;
	logic [47:0]            wbuf_q;
	logic [2:0]             wcnt_q;
	logic                   wlong_q;
	logic                   esc_q;
	logic [LINE_BITS-1:0]   line_q;
	logic [LENGTH_BITS-1:0] len_q;

	result_t    res_s1 [MAX_RES];
	logic [2:0] cnt_s1;
	logic [2:0] idx_q;
	logic       bvalid_q;

	mode_t                  mode_n;
	logic [7:0]             held_n;
	logic [47:0]            wbuf_n;
	logic [2:0]             wcnt_n;
	logic                   wlong_n;
	logic                   esc_n;
	logic [LINE_BITS-1:0]   line_n;
	logic [LENGTH_BITS-1:0] len_n;
	result_t                res_n [MAX_RES];
	logic [2:0]             n;

	logic in_fire, out_fire, at_last;

	function automatic logic [15:0] line16(input logic [LINE_BITS-1:0] v);
		logic [LINE_BITS+15:0] t;
		t = {16'd0, v};
		return t[15:0];
	endfunction

	function automatic logic [15:0] len16(input logic [LENGTH_BITS-1:0] v);
		logic [LENGTH_BITS+15:0] t;
		t = {16'd0, v};
		return t[15:0];
	endfunction

	always_comb begin
		logic [7:0] c;
		logic       fin;
		logic       used;
		logic [4:0] kc;
		c       = text.source_byte;
		fin     = text.final_byte;
		used    = 1'b0;
		kc      = 5'd0;
		mode_n  = mode_q;
		held_n  = held_q;
		wbuf_n  = wbuf_q;
		wcnt_n  = wcnt_q;
		wlong_n = wlong_q;
		esc_n   = esc_q;
		line_n  = line_q;
		len_n   = len_q;
		n       = 3'd0;
		for (int i = 0; i < MAX_RES; i++) res_n[i] = '0;

		unique case (mode_q)
			MODE_IDENT: begin
				if (is_alpha(c)) begin
					used = 1'b1;
					if (wcnt_n < 3'(WORD_MAX)) begin
						wbuf_n = {wbuf_n[39:0], c};
						wcnt_n = wcnt_n + 3'd1;
					end else begin
						wlong_n = 1'b1;
					end
					res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
				end else begin
					kc = wlong_n ? 5'd0 : keyword_lookup(wbuf_n, wcnt_n);
					res_n[n] = '{1'b1, (kc != 5'd0) ? KIND_KEYWORD : KIND_IDENT, kc, 8'd0,
						line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
					len_n = '0;
					wbuf_n = '0; wcnt_n = '0; wlong_n = 1'b0;
					mode_n = MODE_IDLE;
				end
			end
			MODE_NUM: begin
				if (is_digit(c) || c == CH_DOT) begin
					used = 1'b1;
					res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
				end else begin
					res_n[n] = '{1'b1, KIND_NUM, 5'd0, 8'd0, line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
					len_n = '0;
					mode_n = MODE_IDLE;
				end
			end
			MODE_STR: begin
				used = 1'b1;
				if (esc_n) begin
					esc_n = 1'b0;
					res_n[n] = '{1'b0, 4'd0, 5'd0,
						(c == 8'h74) ? CH_TAB : ((c == 8'h6e) ? CH_NL : c),
						line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
				end else if (c == CH_BSL) begin
					esc_n = 1'b1;
				end else if (is_quote(c)) begin
					res_n[n] = '{1'b1, KIND_STR, 5'd0, 8'd0, line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
					len_n = '0;
					mode_n = MODE_IDLE;
				end else begin
					res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
				end
			end
			MODE_COMMENT: begin
				if (c == CH_NL) begin
					res_n[n] = '{1'b1, KIND_COMMENT, 5'd0, 8'd0, line16(line_n), len16(len_n),
						1'b0};
					n = n + 3'd1;
					len_n = '0;
					mode_n = MODE_IDLE;
				end else begin
					used = 1'b1;
					res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
				end
			end
			MODE_OPER: begin
				if (c == CH_EQ) begin
					used = 1'b1;
					res_n[n] = '{1'b0, 4'd0, 5'd0, held_n, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
					res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
					res_n[n] = '{1'b1, KIND_OP, 5'd0, 8'd0, line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
					len_n = '0;
					mode_n = MODE_IDLE;
				end else if (held_n == CH_MINUS && c == CH_MINUS) begin
					used = 1'b1;
					mode_n = MODE_COMMENT;
					len_n = '0;
				end else begin
					res_n[n] = '{1'b0, 4'd0, 5'd0, held_n, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
					res_n[n] = '{1'b1, KIND_OP, 5'd0, 8'd0, line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
					len_n = '0;
					mode_n = MODE_IDLE;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		// byte that ended a token, or any byte met in idle, is scanned here
		if (!used) begin
			len_n = '0;
			if (c == CH_SP || c == CH_TAB) begin
				len_n = '0;
			end else if (c == CH_NL) begin
				if (line_n != LINE_MAX) line_n = line_n + LINE_ONE;
			end else if (is_alpha(c)) begin
				mode_n = MODE_IDENT;
				wbuf_n = {40'd0, c};
				wcnt_n = 3'd1;
				wlong_n = 1'b0;
				res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
				n = n + 3'd1;
				len_n = LENGTH_BITS'(1);
			end else if (c == 8'h3b || c == 8'h2c) begin
				res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
				n = n + 3'd1;
				res_n[n] = '{1'b1, KIND_PUNCT, 5'd0, 8'd0, line16(line_n), 16'd1, 1'b0};
				n = n + 3'd1;
			end else if (c == 8'h5b || c == 8'h5d || c == 8'h28 || c == 8'h29) begin
				res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
				n = n + 3'd1;
				res_n[n] = '{1'b1, KIND_SEP, 5'd0, 8'd0, line16(line_n), 16'd1, 1'b0};
				n = n + 3'd1;
			end else if (is_oper(c)) begin
				held_n = c;
				mode_n = MODE_OPER;
			end else if (is_digit(c)) begin
				mode_n = MODE_NUM;
				res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
				n = n + 3'd1;
				len_n = LENGTH_BITS'(1);
			end else if (is_quote(c)) begin
				mode_n = MODE_STR;
				esc_n = 1'b0;
			end else begin
				res_n[n] = '{1'b0, 4'd0, 5'd0, c, line16(line_n), 16'd0, 1'b0};
				n = n + 3'd1;
				res_n[n] = '{1'b1, KIND_BAD, 5'd0, 8'd0, line16(line_n), 16'd1, 1'b0};
				n = n + 3'd1;
			end
		end

		// end of program closes the open token, adds an EOF record and resets the state
		if (fin) begin
			unique case (mode_n)
				MODE_IDENT: begin
					kc = wlong_n ? 5'd0 : keyword_lookup(wbuf_n, wcnt_n);
					res_n[n] = '{1'b1, (kc != 5'd0) ? KIND_KEYWORD : KIND_IDENT, kc, 8'd0,
						line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
				end
				MODE_NUM: begin
					res_n[n] = '{1'b1, KIND_NUM, 5'd0, 8'd0, line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
				end
				MODE_STR: begin
					res_n[n] = '{1'b1, KIND_UNTERM, 5'd0, 8'd0, line16(line_n), len16(len_n),
						1'b0};
					n = n + 3'd1;
				end
				MODE_COMMENT: begin
					res_n[n] = '{1'b1, KIND_COMMENT, 5'd0, 8'd0, line16(line_n), len16(len_n),
						1'b0};
					n = n + 3'd1;
				end
				MODE_OPER: begin
					res_n[n] = '{1'b0, 4'd0, 5'd0, held_n, line16(line_n), 16'd0, 1'b0};
					n = n + 3'd1;
					if (len_n != LEN_MAX) len_n = len_n + LEN_ONE;
					res_n[n] = '{1'b1, KIND_OP, 5'd0, 8'd0, line16(line_n), len16(len_n), 1'b0};
					n = n + 3'd1;
				end
				default: begin
					kc = 5'd0;
				end
			endcase
			res_n[n] = '{1'b1, KIND_EOF, 5'd0, 8'd0, line16(line_n), 16'd0, 1'b0};
			n = n + 3'd1;
			mode_n  = MODE_IDLE;
			held_n  = '0;
			wbuf_n  = '0;
			wcnt_n  = '0;
			wlong_n = 1'b0;
			esc_n   = 1'b0;
			line_n  = LINE_ONE;
			len_n   = '0;
		end

		if (n != 3'd0) res_n[n - 3'd1].last_result = 1'b1;
	end

	assign at_last    = (idx_q == cnt_s1 - 3'd1);
	assign out_fire   = bvalid_q && token.ready;
	assign text.ready = !bvalid_q || (token.ready && at_last);
	assign in_fire    = text.valid && text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			held_q   <= '0;
			wbuf_q   <= '0;
			wcnt_q   <= '0;
			wlong_q  <= 1'b0;
			esc_q    <= 1'b0;
			line_q   <= LINE_ONE;
			len_q    <= '0;
			bvalid_q <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (in_fire) begin
				mode_q  <= mode_n;
				held_q  <= held_n;
				wbuf_q  <= wbuf_n;
				wcnt_q  <= wcnt_n;
				wlong_q <= wlong_n;
				esc_q   <= esc_n;
				line_q  <= line_n;
				len_q   <= len_n;
			end
			if (in_fire) begin
				bvalid_q <= (n != 3'd0);
				idx_q    <= '0;
			end else if (out_fire) begin
				if (at_last) bvalid_q <= 1'b0;
				else idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_s1 <= res_n;
			cnt_s1 <= n;
		end
	end

	assign token.valid        = bvalid_q;
	assign token.is_record    = res_s1[idx_q].is_record;
	assign token.token_kind   = res_s1[idx_q].token_kind;
	assign token.keyword_code = res_s1[idx_q].keyword_code;
	assign token.payload_byte = res_s1[idx_q].payload_byte;
	assign token.line_number  = res_s1[idx_q].line_number;
	assign token.token_length = res_s1[idx_q].token_length;
	assign token.last_result  = res_s1[idx_q].last_result;

endmodule
`default_nettype wire
